>>> rtl/pls_pkg.sv
// shared types, command and status codes for the positional list store
`default_nettype none
package pls_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int CMD_W        = 3;
	localparam int POS_W        = 7;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 7;
	localparam int IN_W         = CMD_W + DATA_W + POS_W;
	localparam int OUT_W        = STATUS_W + DATA_W + 1 + COUNT_W;
	localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd6;
	localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd7;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
		logic [CMD_W-1:0]         command;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]       entry_count;
		logic                     found;
		logic signed [DATA_W-1:0] removed_value;
		logic [STATUS_W-1:0]      status;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/pls_ram.sv
// generic single write port ram with registered read
`default_nettype none
module pls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/pls_core.sv
// command decode and shift/search sequencer around the entry ram
`default_nettype none
module pls_core #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pls_pkg::in_item_t in_item,
	output logic                  done,
	input  wire logic             done_ack,
	output pls_pkg::result_t      result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = ((LW > pls_pkg::POS_W) ? LW : pls_pkg::POS_W) + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_PUT  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	localparam logic [1:0] M_UP   = 2'd0;
	localparam logic [1:0] M_DN   = 2'd1;
	localparam logic [1:0] M_SRCH = 2'd2;

	localparam logic [1:0] K_WR  = 2'd0;
	localparam logic [1:0] K_CAP = 2'd1;
	localparam logic [1:0] K_CMP = 2'd2;

	logic [1:0]                        state_q;
	logic [1:0]                        mode_q;
	logic [LW-1:0]                     len_q;
	logic [AW-1:0]                     idx_q;
	logic [AW-1:0]                     rp_q;
	logic [LW-1:0]                     cnt_q;
	logic                              pv_q;
	logic [AW-1:0]                     pa_q;
	logic [1:0]                        pk_q;
	logic [pls_pkg::DATA_W-1:0]        val_q;
	logic [pls_pkg::STATUS_W-1:0]      status_q;
	logic [pls_pkg::DATA_W-1:0]        removed_q;
	logic                              found_q;

	logic [pls_pkg::STATUS_W-1:0]      d_status;
	logic                              d_run;
	logic [1:0]                        d_mode;
	logic [AW-1:0]                     d_idx;
	logic                              full;
	logic                              empty;
	logic [CW-1:0]                     pos_w;
	logic [CW-1:0]                     len_w;

	logic                              ram_we;
	logic [AW-1:0]                     ram_waddr;
	logic [pls_pkg::DATA_W-1:0]        ram_wdata;
	logic [pls_pkg::DATA_W-1:0]        ram_rdata;

	assign full  = (len_q == LW'(CAPACITY));
	assign empty = (len_q == '0);
	assign pos_w = CW'(in_item.position);
	assign len_w = CW'(len_q);

	always_comb begin
		d_status = pls_pkg::ST_OK;
		d_run    = 1'b0;
		d_mode   = M_SRCH;
		d_idx    = '0;
		case (in_item.command)
			pls_pkg::CMD_INS_FRONT: begin
				if (full) begin
					d_status = pls_pkg::ST_FULL;
				end else begin
					d_run  = 1'b1;
					d_mode = M_UP;
				end
			end
			pls_pkg::CMD_INS_REAR: begin
				if (full) begin
					d_status = pls_pkg::ST_FULL;
				end else begin
					d_run  = 1'b1;
					d_mode = M_UP;
					d_idx  = AW'(len_q);
				end
			end
			pls_pkg::CMD_INS_AT: begin
				if (full) begin
					d_status = pls_pkg::ST_FULL;
				end else if (pos_w == '0 || pos_w > len_w + CW'(1)) begin
					d_status = pls_pkg::ST_BADPOS;
				end else begin
					d_run  = 1'b1;
					d_mode = M_UP;
					d_idx  = AW'(pos_w - CW'(1));
				end
			end
			pls_pkg::CMD_DEL_FRONT: begin
				if (empty) begin
					d_status = pls_pkg::ST_EMPTY;
				end else begin
					d_run  = 1'b1;
					d_mode = M_DN;
				end
			end
			pls_pkg::CMD_DEL_REAR: begin
				if (empty) begin
					d_status = pls_pkg::ST_EMPTY;
				end else begin
					d_run  = 1'b1;
					d_mode = M_DN;
					d_idx  = AW'(len_q - LW'(1));
				end
			end
			pls_pkg::CMD_DEL_AT: begin
				if (empty) begin
					d_status = pls_pkg::ST_EMPTY;
				end else if (pos_w == '0 || pos_w > len_w) begin
					d_status = pls_pkg::ST_BADPOS;
				end else begin
					d_run  = 1'b1;
					d_mode = M_DN;
					d_idx  = AW'(pos_w - CW'(1));
				end
			end
			pls_pkg::CMD_SEARCH: begin
				d_run  = 1'b1;
				d_mode = M_SRCH;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			pv_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					pv_q <= 1'b0;
					if (in_valid) begin
						state_q <= d_run ? S_RUN : S_FIN;
					end
				end
				S_RUN: begin
					if (cnt_q != '0) begin
						pv_q <= 1'b1;
					end else begin
						pv_q <= 1'b0;
						if (mode_q == M_UP) begin
							state_q <= S_PUT;
						end else begin
							state_q <= S_FIN;
							if (mode_q == M_DN) begin
								len_q <= len_q - LW'(1);
							end
						end
					end
				end
				S_PUT: begin
					len_q   <= len_q + LW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (done_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: one ram read and at most one ram write per cycle
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			val_q     <= in_item.item_value;
			status_q  <= d_status;
			removed_q <= '0;
			found_q   <= 1'b0;
			mode_q    <= d_mode;
			idx_q     <= d_idx;
			if (d_mode == M_SRCH) begin
				cnt_q <= len_q;
				rp_q  <= '0;
			end else begin
				cnt_q <= len_q - LW'(d_idx);
				rp_q  <= (d_mode == M_UP) ? AW'(len_q - LW'(1)) : d_idx;
			end
		end else if (state_q == S_RUN) begin
			if (pv_q && pk_q == K_CAP) begin
				removed_q <= ram_rdata;
			end
			if (pv_q && pk_q == K_CMP && ram_rdata == val_q) begin
				found_q <= 1'b1;
			end
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - LW'(1);
				if (mode_q == M_UP) begin
					pa_q <= rp_q + AW'(1);
					rp_q <= rp_q - AW'(1);
					pk_q <= K_WR;
				end else begin
					pa_q <= rp_q - AW'(1);
					rp_q <= rp_q + AW'(1);
					if (mode_q == M_SRCH) begin
						pk_q <= K_CMP;
					end else if (rp_q == idx_q) begin
						pk_q <= K_CAP;
					end else begin
						pk_q <= K_WR;
					end
				end
			end
		end
	end

	assign ram_we    = (state_q == S_PUT) || (state_q == S_RUN && pv_q && pk_q == K_WR);
	assign ram_waddr = (state_q == S_PUT) ? idx_q : pa_q;
	assign ram_wdata = (state_q == S_PUT) ? val_q : ram_rdata;

	pls_ram #(
		.WIDTH(pls_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rp_q),
		.rdata(ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign done     = (state_q == S_FIN);

	assign result.status        = status_q;
	assign result.removed_value = removed_q;
	assign result.found         = found_q;
	assign result.entry_count   = pls_pkg::COUNT_W'(len_q);

endmodule
`default_nettype wire

>>> rtl/positional_list_store.sv
// Bounded ordered list of signed 32-bit values held in a single-port-pair ram. One command is
// worked at a time and the input is not ready meanwhile; a finished result waits in an output
// register so the next command is taken while it is pending. Every entry move, compare or
// removal read goes through the one ram read port and write port, one entry per cycle; insert
// and delete pass the entries from their index to the end, search passes every entry, and count
// and rejected commands make no ram pass. No clearing pass after reset.
`default_nettype none
module positional_list_store #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// command[2:0], item_value[34:3], position[41:35], zero fill above
	input  wire logic [pls_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// status[1:0], removed_value[33:2], found[34], entry_count[41:35], zero fill above
	output logic      [pls_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	pls_pkg::in_item_t in_item;
	pls_pkg::result_t  core_res;
	pls_pkg::result_t  res_q;
	logic              ov_q;
	logic              done;
	logic              done_ack;

	assign in_item  = pls_pkg::in_item_t'(s_axis_tdata[pls_pkg::IN_W-1:0]);
	assign done_ack = !ov_q || m_axis_tready;

	pls_core #(
		.CAPACITY(CAPACITY)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_item (in_item),
		.done    (done),
		.done_ack(done_ack),
		.result  (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (done && done_ack) begin
			ov_q <= 1'b1;
		end else if (m_axis_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && done_ack) begin
			res_q <= core_res;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = pls_pkg::OUT_TDATA_W'(res_q);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a transaction");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_q.status != pls_pkg::ST_OK |->
			res_q.removed_value == '0 && !res_q.found)
		else $error("error result carries removed value or found flag");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_q.found |-> res_q.removed_value == '0)
		else $error("search result carries a removed value");
`endif

endmodule
`default_nettype wire

>>> verif/pls_list_mirror_pkg.sv
// shadow copy of the positional list used to predict and check every result transaction
`timescale 1ns / 1ps
package pls_list_mirror_pkg;
	import pls_pkg::*;

	class list_mirror;
		logic signed [DATA_W-1:0] shadow_entries[$];
		result_t results_due[$];
		int errors;
		int checked;
		int status_seen[4];
		int search_hits;

		function void note_command(in_item_t item);
			result_t res;
			int len;
			int idx;
			len = shadow_entries.size();
			res = '0;
			res.status = ST_OK;
			case (item.command)
				CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_AT: begin
					idx = (item.command == CMD_INS_FRONT) ? 0 :
						(item.command == CMD_INS_REAR) ? len : int'(item.position) - 1;
					if (len >= CAPACITY_DEF) begin
						res.status = ST_FULL;
					end else if (item.command == CMD_INS_AT &&
						(item.position == 0 || int'(item.position) > len + 1)) begin
						res.status = ST_BADPOS;
					end else begin
						shadow_entries.insert(idx, item.item_value);
					end
				end
				CMD_DEL_FRONT, CMD_DEL_REAR, CMD_DEL_AT: begin
					idx = (item.command == CMD_DEL_FRONT) ? 0 :
						(item.command == CMD_DEL_REAR) ? len - 1 : int'(item.position) - 1;
					if (len == 0) begin
						res.status = ST_EMPTY;
					end else if (item.command == CMD_DEL_AT &&
						(item.position == 0 || int'(item.position) > len)) begin
						res.status = ST_BADPOS;
					end else begin
						res.removed_value = shadow_entries[idx];
						shadow_entries.delete(idx);
					end
				end
				CMD_SEARCH: begin
					foreach (shadow_entries[i])
						if (shadow_entries[i] == item.item_value)
							res.found = 1'b1;
					if (res.found)
						search_hits++;
				end
				default: begin
				end
			endcase
			res.entry_count = COUNT_W'(shadow_entries.size());
			status_seen[res.status]++;
			results_due.push_back(res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			checked++;
			if (results_due.size() == 0) begin
				$error("result transaction with nothing outstanding");
				errors++;
				return;
			end
			want = results_due.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.removed_value !== want.removed_value) begin
				$error("removed_value: expected %0d, got %0d", want.removed_value,
					got.removed_value);
				errors++;
			end
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count,
					got.entry_count);
				errors++;
			end
		endfunction
	endclass

endpackage

>>> verif/positional_list_store_tb.sv
// testbench for the positional list store: directed corner commands, then random fill/drain/mix phases
`timescale 1ns / 1ps
module positional_list_store_tb;
	import pls_pkg::*;
	import pls_list_mirror_pkg::*;

	localparam int LIST_CAP    = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	list_mirror mirror;
	int cycle_count = 0;
	bit steady;

	positional_list_store #(.CAPACITY(LIST_CAP)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			mirror.check_result(result_t'(m_axis_tdata[OUT_W-1:0]));

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value,
		logic [POS_W-1:0] pos);
		in_item_t item;
		int gap;
		item.command = cmd;
		item.item_value = value;
		item.position = pos;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= IN_TDATA_W'(item);
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		mirror.note_command(item);
	endtask

	task automatic run_phase(phase_t mode, int count);
		int roll;
		int len;
		logic [CMD_W-1:0] cmd;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0] pos;
		for (int n = 0; n < count; n++) begin
			len = mirror.shadow_entries.size();
			roll = $urandom_range(0, 99);
			case (mode)
				PH_FILL: cmd = (roll < 70) ? CMD_W'($urandom_range(CMD_INS_FRONT, CMD_INS_AT)) :
					(roll < 85) ? CMD_W'($urandom_range(CMD_DEL_FRONT, CMD_DEL_AT)) :
					CMD_W'($urandom_range(CMD_SEARCH, CMD_COUNT));
				PH_DRAIN: cmd = (roll < 20) ? CMD_W'($urandom_range(CMD_INS_FRONT, CMD_INS_AT)) :
					(roll < 80) ? CMD_W'($urandom_range(CMD_DEL_FRONT, CMD_DEL_AT)) :
					CMD_W'($urandom_range(CMD_SEARCH, CMD_COUNT));
				default: cmd = CMD_W'($urandom_range(CMD_INS_FRONT, CMD_COUNT));
			endcase
			if ($urandom_range(0, 9) < 3)
				value = DATA_W'(int'($urandom_range(0, 6)) - 3);
			else
				value = $urandom;
			if (cmd == CMD_SEARCH && len > 0 && $urandom_range(0, 1))
				value = mirror.shadow_entries[$urandom_range(0, len - 1)];
			if ($urandom_range(0, 99) < 15)
				pos = POS_W'($urandom_range(0, 127));
			else if (cmd == CMD_INS_AT)
				pos = POS_W'($urandom_range(1, len + 1));
			else if (cmd == CMD_DEL_AT && len > 0)
				pos = POS_W'($urandom_range(1, len));
			else
				pos = POS_W'($urandom_range(0, 127));
			send_command(cmd, value, pos);
		end
	endtask

	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			int stall;
			stall = pick_gap();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		steady = 1'b0;
		mirror = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners
		send_command(CMD_COUNT, 0, 0);
		send_command(CMD_DEL_FRONT, 0, 0);
		send_command(CMD_DEL_REAR, 0, 0);
		send_command(CMD_DEL_AT, 0, 0);
		send_command(CMD_DEL_AT, 0, 127);
		send_command(CMD_SEARCH, 0, 0);
		send_command(CMD_INS_AT, 5, 0);
		send_command(CMD_INS_AT, 5, 2);
		// value extremes and edges of the valid position range
		send_command(CMD_INS_FRONT, 32'sh7fffffff, 0);
		send_command(CMD_INS_REAR, 32'sh80000000, 127);
		send_command(CMD_INS_AT, -1, 1);
		send_command(CMD_INS_AT, 0, 4);
		send_command(CMD_INS_AT, 7, 6);
		send_command(CMD_SEARCH, 32'sh80000000, 0);
		send_command(CMD_SEARCH, 12345, 0);
		send_command(CMD_DEL_AT, 0, 0);
		send_command(CMD_DEL_AT, 0, 5);
		send_command(CMD_DEL_AT, 0, 127);
		send_command(CMD_DEL_AT, 0, 2);
		send_command(CMD_DEL_REAR, 0, 0);
		send_command(CMD_DEL_FRONT, 0, 0);
		send_command(CMD_COUNT, 0, 0);

		s_axis_tvalid <= 1'b0;
		while (mirror.results_due.size() != 0) @(posedge clk);

		run_phase(PH_FILL, 250);
		run_phase(PH_DRAIN, 250);
		run_phase(PH_MIX, 200);
		steady = 1'b1;
		run_phase(PH_FILL, 150);
		run_phase(PH_DRAIN, 150);
		steady = 1'b0;
		run_phase(PH_MIX, 100);
		run_phase(PH_FILL, 150);
		run_phase(PH_DRAIN, 150);

		@(posedge clk);
		s_axis_tvalid <= 1'b0;
		while (mirror.results_due.size() != 0) @(posedge clk);
		repeat (LIST_CAP + 8) @(posedge clk);

		$display("%0d results checked: ok %0d, empty %0d, bad position %0d, full %0d",
			mirror.checked, mirror.status_seen[ST_OK], mirror.status_seen[ST_EMPTY],
			mirror.status_seen[ST_BADPOS], mirror.status_seen[ST_FULL]);
		$display("%0d searches found their key; %0d mismatching fields",
			mirror.search_hits, mirror.errors);
		if (mirror.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
